[rtl/pqgc_pkg.sv]
// ----------------------------------------------------------------------------
// pqgc_pkg: shared types and constants for the glyph classifier
// widths, glyph and color codes, register map, lane and word structs
// ----------------------------------------------------------------------------
package pqgc_pkg;

    localparam int SHADE_COUNT = 8;
    localparam int TRACK_COUNT = 3;
    localparam int LANE_COUNT  = 4;

    localparam int PIX_W   = 8;
    localparam int GLYPH_W = 5;
    localparam int CLASS_W = 4;
    localparam int CFG_IDX_W = 3;

    // glyph codes above the occupancy range
    localparam logic [GLYPH_W-1:0] GLYPH_X     = GLYPH_W'(16);
    localparam logic [GLYPH_W-1:0] GLYPH_S     = GLYPH_W'(17);
    localparam logic [GLYPH_W-1:0] GLYPH_COLON = GLYPH_W'(18);
    localparam logic [GLYPH_W-1:0] GLYPH_O     = GLYPH_W'(19);

    // color classes
    localparam logic [CLASS_W-1:0] CLS_NONE      = CLASS_W'(0);
    localparam logic [CLASS_W-1:0] CLS_LOCATION  = CLASS_W'(1);
    localparam logic [CLASS_W-1:0] CLS_SUN       = CLASS_W'(2);
    localparam logic [CLASS_W-1:0] CLS_BORDER    = CLASS_W'(3);
    localparam int                 CLS_SHADE0    = 4;
    localparam int                 CLS_SHADE_MAX = 11;
    localparam logic [CLASS_W-1:0] CLS_LINE      = CLASS_W'(12);
    localparam int                 CLS_TRACK0    = 13;
    localparam int                 CLS_TRACK_MAX = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUN_ACTIVE       = 3'd0,
        REG_HIGHLIGHT_INDEX  = 3'd1,
        REG_SUN_INDEX        = 3'd2,
        REG_SUN_BORDER_INDEX = 3'd3,
        REG_LINE_INDEX       = 3'd4,
        REG_TRACK_BASE_INDEX = 3'd5,
        REG_SHADE_BASE_INDEX = 3'd6,
        REG_NEWLINE_ON_LAST  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic             sun_active;
        logic [PIX_W-1:0] highlight_index;
        logic [PIX_W-1:0] sun_index;
        logic [PIX_W-1:0] sun_border_index;
        logic [PIX_W-1:0] line_index;
        logic [PIX_W-1:0] track_base_index;
        logic [PIX_W-1:0] shade_base_index;
        logic             newline_on_last;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_top_left;
        logic [PIX_W-1:0] pixel_top_right;
        logic [PIX_W-1:0] pixel_bottom_left;
        logic [PIX_W-1:0] pixel_bottom_right;
        logic             end_of_row;
        logic             final_row;
    } cell_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_code;
        logic [CLASS_W-1:0] color_class;
        logic               reset_after;
        logic               newline_after;
    } result_t;

    // what one lane found for its pixel
    typedef struct packed {
        logic                   highlight;
        logic                   sun;
        logic                   border;
        logic                   line;
        logic                   nonzero;
        logic [TRACK_COUNT-1:0] track;
        logic [SHADE_COUNT-1:0] shade;
    } lane_hit_t;

    function automatic logic [CLASS_W-1:0] track_class(input int i);
        int c;
        c = CLS_TRACK0 + i;
        if (c > CLS_TRACK_MAX)
        begin
            c = CLS_TRACK_MAX;
        end
        return CLASS_W'(c);
    endfunction

    function automatic logic [CLASS_W-1:0] shade_class(input int i);
        int c;
        c = CLS_SHADE0 + i;
        if (c > CLS_SHADE_MAX)
        begin
            c = CLS_SHADE_MAX;
        end
        return CLASS_W'(c);
    endfunction

endpackage

[rtl/pqgc_lane.sv]
// ----------------------------------------------------------------------------
// pqgc_lane: per-pixel match lane
// compares one palette index against every configured index, registered
// ----------------------------------------------------------------------------
module pqgc_lane
(
    input  logic                          clk,
    input  logic                          load,
    input  logic [pqgc_pkg::PIX_W-1:0]    pixel,
    input  pqgc_pkg::cfg_t                cfg,
    output pqgc_pkg::lane_hit_t           hit_reg
);

    pqgc_pkg::lane_hit_t hit_next;

    always_comb
    begin
        hit_next.highlight = (pixel == cfg.highlight_index);
        hit_next.sun       = (pixel == cfg.sun_index);
        hit_next.border    = (pixel == cfg.sun_border_index);
        hit_next.line      = (pixel == cfg.line_index);
        hit_next.nonzero   = (pixel != '0);
        // base plus offset wraps at the index width
        for (int i = 0; i < pqgc_pkg::TRACK_COUNT; i++)
        begin
            hit_next.track[i] =
                (pixel == pqgc_pkg::PIX_W'(cfg.track_base_index + pqgc_pkg::PIX_W'(i)));
        end
        for (int i = 0; i < pqgc_pkg::SHADE_COUNT; i++)
        begin
            hit_next.shade[i] =
                (pixel == pqgc_pkg::PIX_W'(cfg.shade_base_index + pqgc_pkg::PIX_W'(i)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

[rtl/pqgc_merge.sv]
// ----------------------------------------------------------------------------
// pqgc_merge: lane merge and priority classification
// ors the lane hits, resolves priority, registers the result word
// ----------------------------------------------------------------------------
module pqgc_merge
(
    input  logic                clk,
    input  logic                load,
    input  pqgc_pkg::lane_hit_t hits [pqgc_pkg::LANE_COUNT],
    input  logic                end_of_row,
    input  logic                final_row,
    input  pqgc_pkg::cfg_t      cfg,
    output pqgc_pkg::result_t   result_reg
);

    pqgc_pkg::lane_hit_t any;
    logic [pqgc_pkg::LANE_COUNT-1:0] occ;
    pqgc_pkg::result_t result_next;
    logic [pqgc_pkg::CLASS_W-1:0] track_cls;
    logic [pqgc_pkg::CLASS_W-1:0] shade_cls;
    logic [pqgc_pkg::CLASS_W-1:0] cls;
    logic track_hit;
    logic shade_hit;
    logic border_hit;
    logic nl;

    always_comb
    begin
        any = '0;
        for (int l = 0; l < pqgc_pkg::LANE_COUNT; l++)
        begin
            any = any | hits[l];
            // lane 0 (top left) lands in the msb
            occ[pqgc_pkg::LANE_COUNT-1-l] = hits[l].nonzero;
        end
    end

    // first matching track and shade, lowest offset wins
    always_comb
    begin
        track_cls = pqgc_pkg::CLS_NONE;
        for (int i = pqgc_pkg::TRACK_COUNT - 1; i >= 0; i--)
        begin
            if (any.track[i])
            begin
                track_cls = pqgc_pkg::track_class(i);
            end
        end
        shade_cls = pqgc_pkg::CLS_NONE;
        for (int i = pqgc_pkg::SHADE_COUNT - 1; i >= 0; i--)
        begin
            if (any.shade[i])
            begin
                shade_cls = pqgc_pkg::shade_class(i);
            end
        end
        track_hit = |any.track;
        shade_hit = |any.shade;
    end

    always_comb
    begin
        nl = end_of_row & (cfg.newline_on_last | ~final_row);
        border_hit = cfg.sun_active & any.border;
        cls = track_cls;
        result_next.newline_after = nl;
        priority if (any.highlight)
        begin
            result_next.glyph_code  = pqgc_pkg::GLYPH_X;
            result_next.color_class = pqgc_pkg::CLS_LOCATION;
            result_next.reset_after = 1'b1;
        end
        else if (cfg.sun_active & any.sun)
        begin
            result_next.glyph_code  = pqgc_pkg::GLYPH_S;
            result_next.color_class = pqgc_pkg::CLS_SUN;
            result_next.reset_after = 1'b1;
        end
        else
        begin
            if (border_hit)
            begin
                cls = pqgc_pkg::CLS_BORDER;
            end
            else if (cfg.sun_active & ~track_hit & shade_hit)
            begin
                cls = shade_cls;
            end
            if (any.line)
            begin
                cls = pqgc_pkg::CLS_LINE;
            end
            if (track_hit)
            begin
                result_next.glyph_code = pqgc_pkg::GLYPH_O;
            end
            else if (border_hit)
            begin
                result_next.glyph_code = pqgc_pkg::GLYPH_COLON;
            end
            else
            begin
                result_next.glyph_code = pqgc_pkg::GLYPH_W'(occ);
            end
            result_next.color_class = cls;
            result_next.reset_after = cfg.sun_active | any.line | track_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[rtl/pixel_quad_to_glyph_classifier.sv]
// ----------------------------------------------------------------------------
// pixel_quad_to_glyph_classifier: 2x2 cell to text-mode glyph
// four match lanes feed one merge stage that picks glyph and color class
// ----------------------------------------------------------------------------
// usage
//   input: a cell word is taken at a clock edge with start high and busy
//   low. busy is high only while in reset and is cleared by the clock edge
//   after reset release, so the block takes one cell every cycle.
//   output: the result word is shown on result for one cycle with done
//   high. the receiver cannot stall, so the result must be taken then.
//   pipeline: lane compare register, then merge/result register.
//   throughput: 1 cell per cycle, set by the two register stages being
//   fully pipelined.
//   configuration: cfg_valid/cfg_ready write channel, cfg_index selects
//   one of the 8 registers, cfg_data carries the value (low bit only for
//   the 1-bit flags). write only while no cell is in flight.
//   reset: configuration registers return to their defaults, the valid
//   pipeline is emptied, busy and cfg_ready track the reset release.
// ----------------------------------------------------------------------------
module pixel_quad_to_glyph_classifier
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pqgc_pkg::cell_t                    quad,
    output logic                               done,
    output pqgc_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pqgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pqgc_pkg::PIX_W-1:0]         cfg_data
);

    pqgc_pkg::cfg_t cfg_reg;
    pqgc_pkg::lane_hit_t hit [pqgc_pkg::LANE_COUNT];
    logic [pqgc_pkg::PIX_W-1:0] pixel [pqgc_pkg::LANE_COUNT];
    logic busy_reg;
    logic accept;
    logic v1_reg;
    logic v2_reg;
    logic eor_reg;
    logic fin_reg;

    // held high through reset, drops at the clock edge after release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = ~busy_reg;
    assign accept    = start & ~busy_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sun_active       <= 1'b0;
            cfg_reg.highlight_index  <= pqgc_pkg::PIX_W'(13);
            cfg_reg.sun_index        <= pqgc_pkg::PIX_W'(14);
            cfg_reg.sun_border_index <= pqgc_pkg::PIX_W'(15);
            cfg_reg.line_index       <= pqgc_pkg::PIX_W'(16);
            cfg_reg.track_base_index <= pqgc_pkg::PIX_W'(10);
            cfg_reg.shade_base_index <= pqgc_pkg::PIX_W'(2);
            cfg_reg.newline_on_last  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pqgc_pkg::cfg_reg_e'(cfg_index))
                pqgc_pkg::REG_SUN_ACTIVE:       cfg_reg.sun_active       <= cfg_data[0];
                pqgc_pkg::REG_HIGHLIGHT_INDEX:  cfg_reg.highlight_index  <= cfg_data;
                pqgc_pkg::REG_SUN_INDEX:        cfg_reg.sun_index        <= cfg_data;
                pqgc_pkg::REG_SUN_BORDER_INDEX: cfg_reg.sun_border_index <= cfg_data;
                pqgc_pkg::REG_LINE_INDEX:       cfg_reg.line_index       <= cfg_data;
                pqgc_pkg::REG_TRACK_BASE_INDEX: cfg_reg.track_base_index <= cfg_data;
                pqgc_pkg::REG_SHADE_BASE_INDEX: cfg_reg.shade_base_index <= cfg_data;
                pqgc_pkg::REG_NEWLINE_ON_LAST:  cfg_reg.newline_on_last  <= cfg_data[0];
            endcase
        end
    end

    // valid pipeline: lane stage, then result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // row flags ride alongside the lane registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            eor_reg <= quad.end_of_row;
            fin_reg <= quad.final_row;
        end
    end

    // lane order sets the occupancy bit order: top left first
    assign pixel[0] = quad.pixel_top_left;
    assign pixel[1] = quad.pixel_top_right;
    assign pixel[2] = quad.pixel_bottom_left;
    assign pixel[3] = quad.pixel_bottom_right;

    for (genvar l = 0; l < pqgc_pkg::LANE_COUNT; l++)
    begin : g_lane
        pqgc_lane u_lane
        (
            .clk     (clk),
            .load    (accept),
            .pixel   (pixel[l]),
            .cfg     (cfg_reg),
            .hit_reg (hit[l])
        );
    end

    pqgc_merge u_merge
    (
        .clk        (clk),
        .load       (v1_reg),
        .hits       (hit),
        .end_of_row (eor_reg),
        .final_row  (fin_reg),
        .cfg        (cfg_reg),
        .result_reg (result)
    );

    assign done = v2_reg;

endmodule

[rtl/pqgc_checker.sv]
// ----------------------------------------------------------------------------
// pqgc_checker: port-level checks for the glyph classifier
// latency, result code ranges and highlight and sun word contents
// ----------------------------------------------------------------------------
module pqgc_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           done,
    input  pqgc_pkg::result_t              result
);

    // every accepted cell yields its word with done high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted cell produced no result");

    // no word without an accepted cell
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result word without accepted cell");

    a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.glyph_code <= pqgc_pkg::GLYPH_O))
        else $error("glyph code out of range");

    // highlight and sun glyphs carry the location or sun class and a color reset
    a_special: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.glyph_code == pqgc_pkg::GLYPH_X
                  || result.glyph_code == pqgc_pkg::GLYPH_S))
        |-> (result.reset_after
             && (result.color_class == pqgc_pkg::CLS_LOCATION
                 || result.color_class == pqgc_pkg::CLS_SUN)))
        else $error("special glyph with wrong class or no reset");

endmodule

bind pixel_quad_to_glyph_classifier pqgc_checker u_pqgc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .result    (result)
);
